// File: hw/rtl/fpsa_pkg.sv
// Shared types, constants and helpers for the free page stack allocator.
// Used by every module of the block but fpsa_ram; depends on nothing.
`default_nettype none

package fpsa_pkg;

    localparam int PAGE_BITS   = 12;
    localparam int ADDR_W      = 32;
    localparam int MAX_PAGES   = 4096;
    localparam int PNUM_W      = ADDR_W - PAGE_BITS;
    localparam int IDX_W       = $clog2(MAX_PAGES);
    localparam int TOP_W       = IDX_W + 1;
    localparam int FREE_W      = 25;
    localparam int WIDE_W      = ADDR_W + 1;
    localparam int MAX_REGIONS = 3;
    localparam int REGION_W    = 2;
    localparam int REG_W       = 3;
    localparam int PADDR_W     = REG_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [TOP_W-1:0]    TOP_FULL    = TOP_W'(MAX_PAGES);
    localparam logic [REGION_W-1:0] REGION_LAST = REGION_W'(MAX_REGIONS - 1);
    localparam logic [WIDE_W:0]     PAGE_STEP   = (WIDE_W + 1)'(1) << PAGE_BITS;

    localparam logic [REG_W-1:0] REG_IMAGE_END     = 3'd0;
    localparam logic [REG_W-1:0] REG_RAM_END       = 3'd1;
    localparam logic [REG_W-1:0] REG_DTB_START     = 3'd2;
    localparam logic [REG_W-1:0] REG_DTB_END       = 3'd3;
    localparam logic [REG_W-1:0] REG_RAMDISK_START = 3'd4;
    localparam logic [REG_W-1:0] REG_RAMDISK_END   = 3'd5;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_POP   = 2'd1,
        S_SETUP = 2'd2,
        S_WALK  = 2'd3
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] image_end;
        logic [ADDR_W-1:0] ram_end;
        logic [ADDR_W-1:0] dtb_start;
        logic [ADDR_W-1:0] dtb_end;
        logic [ADDR_W-1:0] ramdisk_start;
        logic [ADDR_W-1:0] ramdisk_end;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic              bad;
        logic [PNUM_W-1:0] pnum;
    } t_cmd;

    typedef struct packed {
        logic             busy;
        logic             mem_we;
        logic [TOP_W-1:0] top;
    } t_back_stat;

    function automatic logic [WIDE_W-1:0] round_up_page(input logic [WIDE_W-1:0] a);
        logic [WIDE_W:0] sum;
        sum = {1'b0, a} + (WIDE_W + 1)'((1 << PAGE_BITS) - 1);
        return {sum[WIDE_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
    endfunction

    function automatic logic [FREE_W-1:0] free_bytes(input logic [TOP_W-1:0] top);
        return FREE_W'({top, {PAGE_BITS{1'b0}}});
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fpsa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; used for the page stack.
`default_nettype none

module fpsa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fpsa_front.sv
// Front end: accepts request words, checks free addresses, queues commands.
// Depends on fpsa_pkg.
`default_nettype none

module fpsa_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire fpsa_pkg::t_cfg             i_cfg,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_op,
    input  wire logic [fpsa_pkg::ADDR_W-1:0] i_page_address,
    output logic                            o_q_valid,
    output fpsa_pkg::t_cmd                  o_q_cmd,
    input  wire logic                       i_q_pop
);

    fpsa_pkg::t_cmd                    r_q [fpsa_pkg::QUEUE_DEPTH];
    logic [fpsa_pkg::QPTR_W-1:0]       r_wptr;
    logic [fpsa_pkg::QPTR_W-1:0]       r_rptr;
    logic [fpsa_pkg::QCNT_W-1:0]       r_count;
    logic                              s_push;
    logic                              s_bad;
    fpsa_pkg::t_cmd                    s_cmd;

    assign o_in_stall = (r_count == fpsa_pkg::QCNT_W'(fpsa_pkg::QUEUE_DEPTH));
    assign s_push     = i_in_valid && !o_in_stall;

    assign s_bad = (i_page_address[fpsa_pkg::PAGE_BITS-1:0] != '0)
                || (i_page_address < i_cfg.image_end)
                || (i_page_address >= i_cfg.ram_end);

    always_comb begin
        s_cmd.op   = fpsa_pkg::t_op'(i_op);
        s_cmd.bad  = s_bad;
        s_cmd.pnum = i_page_address[fpsa_pkg::ADDR_W-1:fpsa_pkg::PAGE_BITS];
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q[r_wptr] <= s_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (s_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({s_push, i_q_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fpsa_back.sv
// Back end: executes queued commands on the page stack and holds the result word.
// Depends on fpsa_pkg and fpsa_ram.
`default_nettype none

module fpsa_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fpsa_pkg::t_cfg              i_cfg,
    input  wire logic                        i_q_valid,
    input  wire fpsa_pkg::t_cmd              i_q_cmd,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [fpsa_pkg::ADDR_W-1:0]      o_granted_address,
    output fpsa_pkg::t_status                o_status,
    output logic [fpsa_pkg::FREE_W-1:0]      o_free_bytes,
    output fpsa_pkg::t_back_stat             o_stat
);

    fpsa_pkg::t_state                  r_state, n_state;
    logic [fpsa_pkg::TOP_W-1:0]        r_top, n_top;
    logic [fpsa_pkg::WIDE_W-1:0]       r_start, n_start;
    logic [fpsa_pkg::ADDR_W-1:0]       r_end, n_end;
    logic [fpsa_pkg::WIDE_W-1:0]       r_next, n_next;
    logic [fpsa_pkg::WIDE_W-1:0]       r_addr, n_addr;
    logic [fpsa_pkg::REGION_W-1:0]     r_region, n_region;
    logic                              r_bad, n_bad;
    logic                              r_out_valid, n_out_valid;
    logic [fpsa_pkg::ADDR_W-1:0]       r_granted, n_granted;
    fpsa_pkg::t_status                 r_status, n_status;
    logic [fpsa_pkg::FREE_W-1:0]       r_free, n_free;

    logic                              s_slot_free;
    logic                              s_take;
    logic                              s_fits;
    logic                              s_page_ok;
    logic                              s_full;
    logic                              s_last;
    logic [fpsa_pkg::WIDE_W:0]         s_addr_step;
    logic [fpsa_pkg::WIDE_W-1:0]       s_ru_start;
    logic [fpsa_pkg::WIDE_W-1:0]       s_image_w;
    logic [fpsa_pkg::WIDE_W-1:0]       s_ram_w;
    logic [fpsa_pkg::WIDE_W-1:0]       s_dtb_w;
    logic [fpsa_pkg::WIDE_W-1:0]       s_rd_w;

    logic                              s_we;
    logic [fpsa_pkg::IDX_W-1:0]        s_waddr;
    logic [fpsa_pkg::PNUM_W-1:0]       s_wdata;
    logic                              s_re;
    logic [fpsa_pkg::IDX_W-1:0]        s_raddr;
    logic [fpsa_pkg::PNUM_W-1:0]       s_rdata;
    logic [fpsa_pkg::TOP_W-1:0]        s_top_dec;

    fpsa_ram #(
        .WIDTH (fpsa_pkg::PNUM_W),
        .DEPTH (fpsa_pkg::MAX_PAGES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign s_slot_free = !r_out_valid || !i_out_stall;
    assign s_take      = (r_state == fpsa_pkg::S_IDLE) && i_q_valid && s_slot_free;
    assign s_image_w   = {1'b0, i_cfg.image_end};
    assign s_ram_w     = {1'b0, i_cfg.ram_end};
    assign s_dtb_w     = {1'b0, i_cfg.dtb_start};
    assign s_rd_w      = {1'b0, i_cfg.ramdisk_start};
    assign s_addr_step = {1'b0, r_addr} + fpsa_pkg::PAGE_STEP;
    assign s_fits      = (s_addr_step <= {2'b0, r_end});
    assign s_page_ok   = (r_addr >= s_image_w) && (r_addr < s_ram_w);
    assign s_full      = (r_top == fpsa_pkg::TOP_FULL);
    assign s_last      = (r_end == i_cfg.ram_end) || (r_region == fpsa_pkg::REGION_LAST);
    assign s_ru_start  = fpsa_pkg::round_up_page(r_start);
    assign s_top_dec   = r_top - 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpsa_pkg::S_IDLE: begin
                if (s_take) begin
                    case (i_q_cmd.op)
                        fpsa_pkg::OP_ALLOC: begin
                            if (r_top != '0) begin
                                n_state = fpsa_pkg::S_POP;
                            end
                        end
                        fpsa_pkg::OP_INIT: n_state = fpsa_pkg::S_SETUP;
                        default:           n_state = fpsa_pkg::S_IDLE;
                    endcase
                end
            end
            fpsa_pkg::S_POP:   n_state = fpsa_pkg::S_IDLE;
            fpsa_pkg::S_SETUP: n_state = fpsa_pkg::S_WALK;
            fpsa_pkg::S_WALK: begin
                if (s_fits) begin
                    if (s_page_ok && s_full) begin
                        n_state = fpsa_pkg::S_IDLE;
                    end
                end else if (s_last) begin
                    n_state = fpsa_pkg::S_IDLE;
                end else begin
                    n_state = fpsa_pkg::S_SETUP;
                end
            end
            default: n_state = fpsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_top       = r_top;
        n_start     = r_start;
        n_end       = r_end;
        n_next      = r_next;
        n_addr      = r_addr;
        n_region    = r_region;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && i_out_stall;
        n_granted   = r_granted;
        n_status    = r_status;
        n_free      = r_free;
        o_q_pop     = 1'b0;
        s_we        = 1'b0;
        s_waddr     = r_top[fpsa_pkg::IDX_W-1:0];
        s_wdata     = i_q_cmd.pnum;
        s_re        = 1'b0;
        s_raddr     = s_top_dec[fpsa_pkg::IDX_W-1:0];
        case (r_state)
            fpsa_pkg::S_IDLE: begin
                if (s_take) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.op)
                        fpsa_pkg::OP_ALLOC: begin
                            if (r_top == '0) begin
                                n_out_valid = 1'b1;
                                n_granted   = '0;
                                n_status    = fpsa_pkg::ST_EMPTY;
                                n_free      = fpsa_pkg::free_bytes(r_top);
                            end else begin
                                s_re  = 1'b1;
                                n_top = s_top_dec;
                            end
                        end
                        fpsa_pkg::OP_FREE: begin
                            n_out_valid = 1'b1;
                            n_granted   = '0;
                            if (i_q_cmd.bad) begin
                                n_status = fpsa_pkg::ST_BAD;
                            end else if (s_full) begin
                                n_status = fpsa_pkg::ST_FULL;
                            end else begin
                                s_we     = 1'b1;
                                n_top    = r_top + 1'b1;
                                n_status = fpsa_pkg::ST_OK;
                            end
                            n_free = fpsa_pkg::free_bytes(n_top);
                        end
                        fpsa_pkg::OP_INIT: begin
                            n_top    = '0;
                            n_start  = s_image_w;
                            n_region = '0;
                            n_bad    = 1'b0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_granted   = '0;
                            n_status    = fpsa_pkg::ST_OK;
                            n_free      = fpsa_pkg::free_bytes(r_top);
                        end
                    endcase
                end
            end
            fpsa_pkg::S_POP: begin
                n_out_valid = 1'b1;
                n_granted   = {s_rdata, {fpsa_pkg::PAGE_BITS{1'b0}}};
                n_status    = fpsa_pkg::ST_OK;
                n_free      = fpsa_pkg::free_bytes(r_top);
            end
            fpsa_pkg::S_SETUP: begin
                n_end  = i_cfg.ram_end;
                n_next = '0;
                if ((i_cfg.dtb_start != '0) && (r_start < s_dtb_w)) begin
                    if (i_cfg.dtb_start < n_end) begin
                        n_end = i_cfg.dtb_start;
                    end
                    n_next = fpsa_pkg::round_up_page({1'b0, i_cfg.dtb_end});
                end
                if ((i_cfg.ramdisk_start != '0) && (r_start < s_rd_w)) begin
                    if (i_cfg.ramdisk_start < n_end) begin
                        n_end = i_cfg.ramdisk_start;
                    end
                    n_next = fpsa_pkg::round_up_page({1'b0, i_cfg.ramdisk_end});
                end
                n_addr = s_ru_start;
            end
            fpsa_pkg::S_WALK: begin
                s_wdata = r_addr[fpsa_pkg::ADDR_W-1:fpsa_pkg::PAGE_BITS];
                if (s_fits) begin
                    n_addr = s_addr_step[fpsa_pkg::WIDE_W-1:0];
                    if (!s_page_ok) begin
                        n_bad = 1'b1;
                    end else if (s_full) begin
                        n_out_valid = 1'b1;
                        n_granted   = '0;
                        n_status    = fpsa_pkg::ST_FULL;
                        n_free      = fpsa_pkg::free_bytes(r_top);
                    end else begin
                        s_we  = 1'b1;
                        n_top = r_top + 1'b1;
                    end
                end else if (s_last) begin
                    n_out_valid = 1'b1;
                    n_granted   = '0;
                    n_status    = r_bad ? fpsa_pkg::ST_BAD : fpsa_pkg::ST_OK;
                    n_free      = fpsa_pkg::free_bytes(r_top);
                end else begin
                    n_start  = r_next;
                    n_region = r_region + 1'b1;
                end
            end
            default: begin
                n_top = r_top;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpsa_pkg::S_IDLE;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start   <= n_start;
        r_end     <= n_end;
        r_next    <= n_next;
        r_addr    <= n_addr;
        r_region  <= n_region;
        r_bad     <= n_bad;
        r_granted <= n_granted;
        r_status  <= n_status;
        r_free    <= n_free;
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_granted;
    assign o_status          = r_status;
    assign o_free_bytes      = r_free;

    always_comb begin
        o_stat.busy   = (r_state != fpsa_pkg::S_IDLE);
        o_stat.mem_we = s_we;
        o_stat.top    = r_top;
    end

endmodule

`default_nettype wire

// File: hw/rtl/free_page_stack_allocator_core.sv
// Top level of the free page stack allocator: configuration registers, front end, back end.
// Depends on fpsa_pkg, fpsa_front and fpsa_back.
//
// Page-frame allocator holding up to 4096 free 4 KiB pages in a LIFO page stack memory.
// An allocate reads the page stack (state S_POP) before its result; a free or a query needs
// no stack read; each ends in a registered result word; a two-word command queue lets requests
// arrive while a result waits. Initialise walks the memory map one page per cycle
// through the single write port of the page stack: a start step, then per region (at most
// three regions) a setup step and a walk over its pages (pages inside the holes are stepped
// over), and it ends early once the stack is full.
// No clearing pass follows reset.
`default_nettype none

module free_page_stack_allocator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpsa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_op,
    input  wire logic [fpsa_pkg::ADDR_W-1:0]   i_page_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [fpsa_pkg::ADDR_W-1:0]        o_granted_address,
    output logic [1:0]                         o_status,
    output logic [fpsa_pkg::FREE_W-1:0]        o_free_bytes
);

    fpsa_pkg::t_cfg               r_cfg;
    logic [fpsa_pkg::REG_W-1:0]   s_reg;
    logic                         s_cfg_we;
    logic                         s_q_valid;
    fpsa_pkg::t_cmd               s_q_cmd;
    logic                         s_q_pop;
    fpsa_pkg::t_status            s_status;
    fpsa_pkg::t_back_stat         s_stat;

    assign pready   = 1'b1;
    assign s_reg    = paddr[fpsa_pkg::PADDR_W-1:2];
    assign s_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (s_cfg_we) begin
            case (s_reg)
                fpsa_pkg::REG_IMAGE_END:     r_cfg.image_end     <= pwdata;
                fpsa_pkg::REG_RAM_END:       r_cfg.ram_end       <= pwdata;
                fpsa_pkg::REG_DTB_START:     r_cfg.dtb_start     <= pwdata;
                fpsa_pkg::REG_DTB_END:       r_cfg.dtb_end       <= pwdata;
                fpsa_pkg::REG_RAMDISK_START: r_cfg.ramdisk_start <= pwdata;
                fpsa_pkg::REG_RAMDISK_END:   r_cfg.ramdisk_end   <= pwdata;
                default:                     r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (s_reg)
            fpsa_pkg::REG_IMAGE_END:     prdata = r_cfg.image_end;
            fpsa_pkg::REG_RAM_END:       prdata = r_cfg.ram_end;
            fpsa_pkg::REG_DTB_START:     prdata = r_cfg.dtb_start;
            fpsa_pkg::REG_DTB_END:       prdata = r_cfg.dtb_end;
            fpsa_pkg::REG_RAMDISK_START: prdata = r_cfg.ramdisk_start;
            fpsa_pkg::REG_RAMDISK_END:   prdata = r_cfg.ramdisk_end;
            default:                     prdata = '0;
        endcase
    end

    fpsa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_page_address (i_page_address),
        .o_q_valid      (s_q_valid),
        .o_q_cmd        (s_q_cmd),
        .i_q_pop        (s_q_pop)
    );

    fpsa_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (s_q_valid),
        .i_q_cmd           (s_q_cmd),
        .o_q_pop           (s_q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_granted_address (o_granted_address),
        .o_status          (s_status),
        .o_free_bytes      (o_free_bytes),
        .o_stat            (s_stat)
    );

    assign o_status = s_status;

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.top <= fpsa_pkg::TOP_FULL)
        else $error("page count beyond stack depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.mem_we |-> (s_stat.top < fpsa_pkg::TOP_FULL))
        else $error("push into a full page stack");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.busy |-> !o_out_valid)
        else $error("result word pending while a command is in progress");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_q_pop |-> (s_q_valid && !s_stat.busy))
        else $error("command taken while busy or queue empty");

endmodule

`default_nettype wire

// File: sim/free_page_stack_allocator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for free_page_stack_allocator_core: random and directed words
// through the valid/stall ports, memory maps programmed over APB. Needs fpsa_pkg and the RTL.

module free_page_stack_allocator_core_tb;
    import fpsa_pkg::*;

    localparam logic [63:0] PAGE_LEN    = 64'd1 << PAGE_BITS;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          PRINT_LIMIT = 40;

    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
    } t_request;

    typedef struct packed {
        logic [31:0]       granted;
        t_status           status;
        logic [FREE_W-1:0] bytes_free;
    } t_result;

    typedef enum logic [1:0] {
        DRAIN_FREE  = 2'd0,
        DRAIN_PAIRS = 2'd1,
        DRAIN_COIN  = 2'd2,
        DRAIN_SLOW  = 2'd3
    } t_drain;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               o_in_stall;
    t_op                in_op     = OP_ALLOC;
    logic [ADDR_W-1:0]  in_addr   = '0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    logic [ADDR_W-1:0]  o_granted_address;
    logic [1:0]         o_status;
    logic [FREE_W-1:0]  o_free_bytes;

    // allocator state as seen from outside
    logic [PNUM_W-1:0] page_mem [MAX_PAGES];
    int                free_count = 0;
    logic [63:0]       map_image_end = '0, map_ram_end = '0;
    logic [63:0]       map_dtb_start = '0, map_dtb_end = '0;
    logic [63:0]       map_ramdisk_start = '0, map_ramdisk_end = '0;

    t_request pending_q [$];
    t_result  expected_q [$];
    t_request req;
    t_result  want;
    int       burst_left = 0;
    int       gap_left = 0;
    t_drain   drain_mode = DRAIN_FREE;
    logic [5:0] drain_tick = '0;
    int       cycle_count = 0;
    int       errors = 0;
    int       checked = 0;
    int       map_count = 0;
    int       op_seen [4] = '{default: 0};
    int       status_seen [4] = '{default: 0};

    free_page_stack_allocator_core DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (in_op),
        .i_page_address    (in_addr),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .o_free_bytes      (o_free_bytes)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] page_ceil(logic [63:0] a);
        return (a + PAGE_LEN - 1) & ~(PAGE_LEN - 1);
    endfunction

    function automatic t_status push_free_page(logic [63:0] a);
        if (a[PAGE_BITS-1:0] != '0 || a < map_image_end || a >= map_ram_end)
            return ST_BAD;
        if (free_count >= MAX_PAGES)
            return ST_FULL;
        page_mem[free_count] = a[PAGE_BITS +: PNUM_W];
        free_count++;
        return ST_OK;
    endfunction

    function automatic t_status rebuild_free_list();
        logic [63:0] start, stop, after_hole, a;
        logic        skipped;
        t_status     r;
        skipped = 1'b0;
        start = map_image_end;
        free_count = 0;
        for (int region = 0; region < MAX_REGIONS; region++) begin
            stop = map_ram_end;
            after_hole = '0;
            if (map_dtb_start != 0 && start < map_dtb_start) begin
                if (map_dtb_start < stop)
                    stop = map_dtb_start;
                after_hole = page_ceil(map_dtb_end);
            end
            if (map_ramdisk_start != 0 && start < map_ramdisk_start) begin
                if (map_ramdisk_start < stop)
                    stop = map_ramdisk_start;
                after_hole = page_ceil(map_ramdisk_end);
            end
            for (a = page_ceil(start); a + PAGE_LEN <= stop; a += PAGE_LEN) begin
                r = push_free_page(a);
                if (r == ST_FULL)
                    return ST_FULL;
                if (r == ST_BAD)
                    skipped = 1'b1;
            end
            if (stop == map_ram_end)
                break;
            start = after_hole;
        end
        return skipped ? ST_BAD : ST_OK;
    endfunction

    function automatic t_result predict_page_op(t_op op, logic [31:0] addr);
        t_result res;
        res.granted = '0;
        res.status = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (free_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    free_count--;
                    res.granted = {page_mem[free_count], {PAGE_BITS{1'b0}}};
                end
            end
            OP_FREE: res.status = push_free_page({32'b0, addr});
            OP_INIT: res.status = rebuild_free_list();
            default: ;
        endcase
        res.bytes_free = FREE_W'(64'(free_count) << PAGE_BITS);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        if (errors < PRINT_LIMIT)
            $display("ERROR @%0t: %s got %h exp %h", $time, what, got, exp_val);
        errors++;
    endtask

    // sender: bursts of random length, random gaps between them
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_q.push_back(predict_page_op(in_op, in_addr));
                op_seen[in_op]++;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_q.size() != 0) begin
                    req = pending_q.pop_front();
                    in_valid <= 1'b1;
                    in_op <= req.op;
                    in_addr <= req.addr;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each result word, stall in changing modes
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            drain_mode <= DRAIN_FREE;
            drain_tick <= '0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result word", o_granted_address, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_granted_address !== want.granted)
                        report_mismatch("granted_address", o_granted_address, want.granted);
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_free_bytes !== want.bytes_free)
                        report_mismatch("free_bytes", 32'(o_free_bytes), 32'(want.bytes_free));
                    status_seen[want.status]++;
                    checked++;
                end
            end
            drain_tick <= drain_tick + 1'b1;
            if (drain_tick == '0)
                drain_mode <= t_drain'($urandom_range(0, 3));
            case (drain_mode)
                DRAIN_FREE:  out_stall <= 1'b0;
                DRAIN_PAIRS: out_stall <= drain_tick[1];
                DRAIN_COIN:  out_stall <= ($urandom_range(0, 1) == 0);
                default:     out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    endtask

    task automatic push_word(t_op op, logic [31:0] addr);
        t_request r;
        r.op = op;
        r.addr = addr;
        pending_q.push_back(r);
    endtask

    task automatic write_reg(logic [REG_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== val)
            report_mismatch("register read back", prdata, val);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_IMAGE_END:     map_image_end = {32'b0, val};
            REG_RAM_END:       map_ram_end = {32'b0, val};
            REG_DTB_START:     map_dtb_start = {32'b0, val};
            REG_DTB_END:       map_dtb_end = {32'b0, val};
            REG_RAMDISK_START: map_ramdisk_start = {32'b0, val};
            REG_RAMDISK_END:   map_ramdisk_end = {32'b0, val};
            default: ;
        endcase
    endtask

    task automatic program_map(logic [31:0] k_end, logic [31:0] r_end, logic [31:0] d_start,
                               logic [31:0] d_end, logic [31:0] rd_start, logic [31:0] rd_end);
        wait_until_idle();
        write_reg(REG_IMAGE_END, k_end);
        write_reg(REG_RAM_END, r_end);
        write_reg(REG_DTB_START, d_start);
        write_reg(REG_DTB_END, d_end);
        write_reg(REG_RAMDISK_START, rd_start);
        write_reg(REG_RAMDISK_END, rd_end);
        map_count++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_hole_start(logic [31:0] base, int unsigned span);
        if ($urandom_range(0, 3) == 0)
            return '0;
        return base + ($urandom_range(0, span + 2) << PAGE_BITS) + $urandom_range(0, 4095);
    endfunction

    function automatic logic [31:0] pick_hole_end(logic [31:0] s);
        if (s == 0)
            return $urandom;
        if ($urandom_range(0, 4) == 0)
            return s - $urandom_range(0, 6 << PAGE_BITS);
        return s + $urandom_range(0, 12 << PAGE_BITS);
    endfunction

    task automatic program_random_map();
        logic [31:0]  base, d_start, rd_start;
        int unsigned  span;
        base = $urandom & 32'hFFFF_F000;
        if (base > 32'hFFF0_0000)
            base = base & 32'h7FFF_F000;
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 160);
        d_start = pick_hole_start(base, span);
        rd_start = pick_hole_start(base, span);
        program_map(base + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4095)),
                    base + (span << PAGE_BITS)
                        + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4095)),
                    d_start, pick_hole_end(d_start), rd_start, pick_hole_end(rd_start));
    endtask

    task automatic queue_random_items(int count, int init_pct);
        logic [63:0]  lo;
        logic [31:0]  good;
        int unsigned  span, pick;
        t_op          op;
        logic [31:0]  addr;
        lo = page_ceil(map_image_end);
        span = (map_ram_end >= lo + PAGE_LEN) ? int'((map_ram_end - lo) >> PAGE_BITS) : 0;
        push_word(OP_INIT, $urandom);
        for (int n = 1; n < count; n++) begin
            pick = $urandom_range(0, 99);
            addr = $urandom;
            good = (span != 0) ? lo[31:0] + ($urandom_range(0, span - 1) << PAGE_BITS) : addr;
            if (pick < init_pct) begin
                op = OP_INIT;
            end else if (pick < 45) begin
                op = OP_ALLOC;
            end else if (pick < 55) begin
                op = OP_QUERY;
            end else begin
                op = OP_FREE;
                if (pick < 85)
                    addr = good;
                else if (pick < 90)
                    addr = good | $urandom_range(1, 4095);
                else if (pick < 94)
                    addr = 32'(page_ceil(map_ram_end));
                else if (pick < 97)
                    addr = lo[31:0] - PAGE_LEN[31:0];
            end
            push_word(op, addr);
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset map: nothing free, nothing can be freed
        push_word(OP_ALLOC, 32'h0000_0000);
        push_word(OP_QUERY, 32'hFFFF_FFFF);
        push_word(OP_FREE, 32'h0000_0000);
        push_word(OP_INIT, 32'h0000_0000);

        // both holes, unaligned image end
        program_map(32'h8000_0123, 32'h8004_0000, 32'h8001_0000, 32'h8001_1800,
                    32'h8002_0000, 32'h8002_8000);
        push_word(OP_INIT, 32'h0);
        push_word(OP_ALLOC, 32'h0);
        push_word(OP_ALLOC, 32'h0);
        push_word(OP_FREE, 32'h8003_F000);
        push_word(OP_FREE, 32'h8004_0000);
        push_word(OP_FREE, 32'h8000_0000);
        push_word(OP_FREE, 32'h8000_1010);
        push_word(OP_QUERY, 32'h0);

        // overlapping holes that stop advancing
        program_map(32'h0000_1000, 32'h0004_0000, 32'h0001_0000, 32'h0003_0000,
                    32'h0002_0000, 32'h0001_8000);
        push_word(OP_INIT, 32'h0);
        push_word(OP_ALLOC, 32'h0);

        // hole end below image end: pages skipped as bad
        program_map(32'h0002_0000, 32'h0003_0000, 32'h0002_4000, 32'h0000_0100,
                    32'h0000_0000, 32'h0000_0000);
        push_word(OP_INIT, 32'h0);

        // zero dtb start with an end set, ramdisk end rounding past the top
        program_map(32'h0000_1000, 32'h0000_9000, 32'h0000_0000, 32'h0000_3000,
                    32'h0000_5000, 32'hFFFF_FFFF);
        push_word(OP_INIT, 32'h0);

        // all ones
        program_map('1, '1, '1, '1, '1, '1);
        push_word(OP_INIT, 32'h0);
        push_word(OP_FREE, 32'hFFFF_F000);

        // whole address space: store fills up
        program_map(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        push_word(OP_INIT, 32'h0);
        push_word(OP_FREE, 32'h0000_1000);
        push_word(OP_FREE, 32'h0000_1003);
        push_word(OP_ALLOC, 32'h0);
        push_word(OP_FREE, 32'hFFFF_F000);
        push_word(OP_ALLOC, 32'h0);
        wait_until_idle();
        queue_random_items(120, 2);

        for (int m = 0; m < 6; m++) begin
            program_random_map();
            queue_random_items(105, 7);
        end

        wait_until_idle();
        repeat (16) @(posedge clk);
        $display("Run covered %0d words (%0d alloc, %0d free, %0d init, %0d query) over %0d maps",
                 op_seen[OP_ALLOC] + op_seen[OP_FREE] + op_seen[OP_INIT] + op_seen[OP_QUERY],
                 op_seen[OP_ALLOC], op_seen[OP_FREE], op_seen[OP_INIT], op_seen[OP_QUERY],
                 map_count);
        $display("Results checked: %0d (%0d ok, %0d empty, %0d bad address, %0d full), %0d errors",
                 checked, status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BAD],
                 status_seen[ST_FULL], errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
